// File: src/dsv_pkg.sv
// Shared types, constants and helpers for the date string validator.
// No dependencies; compile this file first.
`default_nettype none

package dsv_pkg;

  // Text layout: dd/mm/yyyy
  localparam logic [3:0] DATE_LEN    = 4'd10;
  localparam logic [3:0] POS_SLASH_A = 4'd2;
  localparam logic [3:0] POS_SLASH_B = 4'd5;
  localparam logic [3:0] POS_MONTH   = 4'd3;
  localparam logic [3:0] POS_YEAR_HI = 4'd6;
  localparam logic [3:0] POS_YEAR_LO = 4'd8;

  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [7:0] DIGIT_LOW  = 8'h30;
  localparam logic [7:0] DIGIT_HIGH = 8'h39;

  // Calendar limits
  localparam logic [6:0] MONTHS_PER_YEAR = 7'd12;
  localparam logic [6:0] DAYS_MAX        = 7'd31;
  localparam logic [6:0] DAYS_SHORT      = 7'd30;
  localparam logic [6:0] DAYS_FEB_LEAP   = 7'd29;
  localparam logic [6:0] DAYS_FEB        = 7'd28;
  localparam logic [6:0] MON_FEB         = 7'd2;
  localparam logic [6:0] MON_APR         = 7'd4;
  localparam logic [6:0] MON_JUN         = 7'd6;
  localparam logic [6:0] MON_SEP         = 7'd9;
  localparam logic [6:0] MON_NOV         = 7'd11;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_FORMAT    = 3'd1,
    ERR_DAY       = 3'd2,
    ERR_MONTH     = 3'd3,
    ERR_YEAR      = 3'd4,
    ERR_DAY_MONTH = 3'd5
  } err_code_t;

  typedef struct packed {
    logic [3:0] char_position;
    logic       format_error;
    logic [6:0] day_value;
    logic [6:0] month_value;
    logic [6:0] year_high_pair;
    logic [6:0] year_low_pair;
  } dsv_fields_t;

  // A finished text handed from the scanner to the verdict register.
  typedef struct packed {
    logic        load;
    dsv_fields_t fields;
  } dsv_take_t;

  // Appends one decimal digit to a two-digit accumulator.
  function automatic logic [6:0] add_digit(input logic [6:0] acc, input logic [3:0] d);
    logic [10:0] sum;
    sum = 11'({4'd0, acc} * 11'd10) + {7'd0, d};
    return sum[6:0];
  endfunction

endpackage

`default_nettype wire

// File: src/dsv_char_if.sv
// Character input channel of the date string validator.
// No dependencies.
`default_nettype none

interface dsv_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// File: src/dsv_verdict_if.sv
// Verdict output channel of the date string validator.
// No dependencies.
`default_nettype none

interface dsv_verdict_if;
  logic       valid;
  logic       ready;
  logic       date_ok;
  logic [2:0] error_code;

  modport source (output valid, output date_ok, output error_code, input ready);
  modport sink   (input valid, input date_ok, input error_code, output ready);
endinterface

`default_nettype wire

// File: src/dsv_scan.sv
// Input register and per-character scanner: position, format flag and digit pairs.
// Depends on dsv_pkg and dsv_char_if.
`default_nettype none

module dsv_scan (
  input  wire logic         clk,
  input  wire logic         rst,
  dsv_char_if.sink          char_in,
  input  wire logic         out_free,
  output dsv_pkg::dsv_take_t take
);
  import dsv_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_char;
  logic        s1_last;
  logic        advance;
  logic        is_digit;
  logic [3:0]  digit;
  dsv_fields_t fields;
  dsv_fields_t fields_next;

  // A last character may only move on when the verdict register can take it.
  assign advance       = s1_valid && (!s1_last || out_free);
  assign char_in.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_in.ready) begin
      s1_valid <= char_in.valid;
    end
    if (char_in.valid && char_in.ready) begin
      s1_char <= char_in.char_code;
      s1_last <= char_in.last_char;
    end
  end

  assign is_digit = s1_char inside {[DIGIT_LOW:DIGIT_HIGH]};
  assign digit    = s1_char[3:0];

  always_comb begin
    fields_next = fields;
    if (fields.char_position >= DATE_LEN) begin
      fields_next.format_error = 1'b1;
    end else if (fields.char_position inside {POS_SLASH_A, POS_SLASH_B}) begin
      if (s1_char != SLASH_CHAR) begin
        fields_next.format_error = 1'b1;
      end
    end else if (!is_digit) begin
      fields_next.format_error = 1'b1;
    end else if (fields.char_position < POS_SLASH_A) begin
      fields_next.day_value = add_digit(fields.day_value, digit);
    end else if (fields.char_position < POS_SLASH_B) begin
      fields_next.month_value = add_digit(fields.month_value, digit);
    end else if (fields.char_position < POS_YEAR_LO) begin
      fields_next.year_high_pair = add_digit(fields.year_high_pair, digit);
    end else begin
      fields_next.year_low_pair = add_digit(fields.year_low_pair, digit);
    end
    if (fields.char_position < DATE_LEN) begin
      fields_next.char_position = 4'(fields.char_position + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fields <= '0;
    end else if (advance) begin
      if (s1_last) begin
        fields <= '0;
      end else begin
        fields <= fields_next;
      end
    end
  end

  assign take.load   = advance && s1_last;
  assign take.fields = fields_next;

endmodule

`default_nettype wire

// File: src/dsv_judge.sv
// Calendar checks on a finished text: format, ranges, year zero, month length.
// Depends on dsv_pkg.
`default_nettype none

module dsv_judge (
  input  wire dsv_pkg::dsv_fields_t fields,
  output dsv_pkg::err_code_t        code
);
  import dsv_pkg::*;

  logic year_zero;
  logic leap;
  logic short_month;

  assign year_zero = (fields.year_high_pair == 7'd0) && (fields.year_low_pair == 7'd0);

  // The year is high*100+low and 100 is a multiple of four, so the low pair decides
  // divisibility by four, and a century year is a leap year when the high pair is.
  assign leap = (fields.year_low_pair[1:0] == 2'd0) &&
                ((fields.year_low_pair != 7'd0) || (fields.year_high_pair[1:0] == 2'd0));

  assign short_month = fields.month_value inside {MON_APR, MON_JUN, MON_SEP, MON_NOV};

  always_comb begin
    if (fields.format_error || (fields.char_position != DATE_LEN)) begin
      code = ERR_FORMAT;
    end else if ((fields.month_value == 7'd0) || (fields.month_value > MONTHS_PER_YEAR)) begin
      code = ERR_MONTH;
    end else if ((fields.day_value == 7'd0) || (fields.day_value > DAYS_MAX)) begin
      code = ERR_DAY;
    end else if (year_zero) begin
      code = ERR_YEAR;
    end else if (short_month && (fields.day_value > DAYS_SHORT)) begin
      code = ERR_DAY_MONTH;
    end else if ((fields.month_value == MON_FEB) &&
                 (fields.day_value > (leap ? DAYS_FEB_LEAP : DAYS_FEB))) begin
      code = ERR_DAY_MONTH;
    end else begin
      code = ERR_NONE;
    end
  end

endmodule

`default_nettype wire

// File: src/date_string_validator_top.sv
// Date string validator: checks a dd/mm/yyyy text that arrives one ASCII character per
// word on char_in, with last_char set on the final character, and gives one verdict word
// per text on verdict. The block accepts one character every cycle; the verdict word
// is formed as the last character moves from the input register into the verdict
// register. Throughput pauses only when the verdict register is still held by the sink
// and the character waiting in the input register is itself a last character.
// Depends on dsv_pkg, dsv_char_if, dsv_verdict_if, dsv_scan and dsv_judge.
`default_nettype none

module date_string_validator_top (
  input  wire logic   clk,
  input  wire logic   rst,
  dsv_char_if.sink    char_in,
  dsv_verdict_if.source verdict
);
  import dsv_pkg::*;

  dsv_take_t take;
  err_code_t code;
  logic      out_free;

  // The verdict register can load when it is empty or is being emptied this cycle.
  assign out_free = !verdict.valid || verdict.ready;

  // Scanner: input register, position tracking and digit collection. On a last
  // character it hands the fully updated fields over for judging.
  dsv_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_in),
    .out_free (out_free),
    .take     (take)
  );

  // Checks run on the fields as they stand after the last character.
  dsv_judge u_judge (
    .fields (take.fields),
    .code   (code)
  );

  // Verdict register.
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict.valid <= 1'b0;
    end else if (out_free) begin
      verdict.valid <= take.load;
    end
    if (take.load) begin
      verdict.date_ok    <= (code == ERR_NONE);
      verdict.error_code <= code;
    end
  end

  // A finished text always lands in the verdict register on the next edge.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    take.load |=> verdict.valid)
    else $error("finished text did not produce a verdict");

  // The ok flag and the error code agree.
  a_ok_matches_code: assert property (@(posedge clk) disable iff (rst)
    verdict.valid |-> (verdict.date_ok == (verdict.error_code == ERR_NONE)))
    else $error("date_ok disagrees with error_code");

  // A text of the wrong length is always a format error.
  a_length_format: assert property (@(posedge clk) disable iff (rst)
    (take.load && (take.fields.char_position != DATE_LEN)) |=>
      (verdict.error_code == ERR_FORMAT))
    else $error("wrong-length text not flagged as format error");

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for date_string_validator_top: drives dd/mm/yyyy texts one character
// at a time and checks each verdict word against a calendar predictor kept in the bench.
// Depends on dsv_pkg, dsv_char_if, dsv_verdict_if and the validator RTL.
`default_nettype none

module tb;
  import dsv_pkg::*;

  // This limit is only there to catch a hang.
  localparam int CYCLE_LIMIT = 600000;
  // Tail run after the final drain, before the check for verdict words that never arrived.
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic      ok;
    err_code_t code;
  } verdict_t;

  logic clk;
  logic rst;

  dsv_char_if    char_ch ();
  dsv_verdict_if verdict_ch ();

  date_string_validator_top dut (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_ch),
    .verdict (verdict_ch)
  );

  // Bench copy of the scanner state.
  logic [3:0] scan_pos;
  logic       scan_bad;
  logic [6:0] day_acc;
  logic [6:0] mon_acc;
  logic [6:0] yhi_acc;
  logic [6:0] ylo_acc;

  verdict_t pending_verdicts[$];
  int       error_count;
  int       cycle_count;
  int       stall_left;
  bit       quiet;   // when set, neither side idles

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Clears the scanner copy, both at reset and after every last character.
  task automatic clear_scan();
    scan_pos = '0;
    scan_bad = 1'b0;
    day_acc  = '0;
    mon_acc  = '0;
    yhi_acc  = '0;
    ylo_acc  = '0;
  endtask

  function automatic logic [6:0] push_digit(input logic [6:0] acc, input logic [7:0] c);
    int sum;
    sum = int'(acc) * 10 + int'(c - DIGIT_LOW);
    return sum[6:0];
  endfunction

  // Verdict for the text collected so far. The checks run strictly in order: format first,
  // then month range, day range, zero year, 30-day months and last February.
  function automatic err_code_t calendar_verdict();
    int  day;
    int  mon;
    int  year;
    int  feb_days;
    bit  leap;
    day  = int'(day_acc);
    mon  = int'(mon_acc);
    year = int'(yhi_acc) * 100 + int'(ylo_acc);
    if (scan_bad || scan_pos != DATE_LEN) return ERR_FORMAT;
    if (mon < 1 || mon > 12) return ERR_MONTH;
    if (day < 1 || day > 31) return ERR_DAY;
    if (year == 0) return ERR_YEAR;
    if ((mon == 4 || mon == 6 || mon == 9 || mon == 11) && day > 30) return ERR_DAY_MONTH;
    if (mon == 2) begin
      leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
      feb_days = leap ? 29 : 28;
      if (day > feb_days) return ERR_DAY_MONTH;
    end
    return ERR_NONE;
  endfunction

  // Advances the scanner copy by one accepted character. A flagged last character
  // queues the verdict the block owes for the whole text.
  task automatic scan_char(input logic [7:0] c, input logic last);
    verdict_t v;
    if (scan_pos >= DATE_LEN) begin
      // Every character past the tenth spoils the format.
      scan_bad = 1'b1;
    end else if (scan_pos == POS_SLASH_A || scan_pos == POS_SLASH_B) begin
      if (c != SLASH_CHAR) scan_bad = 1'b1;
    end else if (c < DIGIT_LOW || c > DIGIT_HIGH) begin
      scan_bad = 1'b1;
    end else if (scan_pos < POS_SLASH_A) begin
      day_acc = push_digit(day_acc, c);
    end else if (scan_pos < POS_SLASH_B) begin
      mon_acc = push_digit(mon_acc, c);
    end else if (scan_pos < POS_YEAR_LO) begin
      yhi_acc = push_digit(yhi_acc, c);
    end else begin
      ylo_acc = push_digit(ylo_acc, c);
    end
    if (scan_pos < DATE_LEN) scan_pos = scan_pos + 4'd1;
    if (last) begin
      v.code = calendar_verdict();
      v.ok   = (v.code == ERR_NONE);
      pending_verdicts.push_back(v);
      clear_scan();
    end
  endtask

  // Most gaps are short, a few are long; none at all while quiet is set.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drives one character word at the falling edge, holds it until the block takes it,
  // and then maybe idles the channel for a while. With no gap, valid stays high and the
  // next call simply replaces the payload at the next falling edge.
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    @(negedge clk);
    char_ch.valid     <= 1'b1;
    char_ch.char_code <= c;
    char_ch.last_char <= last;
    do @(posedge clk); while (!char_ch.ready);
    scan_char(c, last);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      char_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sends a whole text, flagging its final character. One position may be swapped for an
  // arbitrary byte, which is how zero bytes get in (a string cannot hold them).
  task automatic send_str(input string s, input int swap_idx, input logic [7:0] swap_ch);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = (i == swap_idx) ? swap_ch : 8'(s[i]);
      send_char(c, i == s.len() - 1);
    end
  endtask

  task automatic send_date(input int day, input int mon, input int year);
    send_str($sformatf("%02d/%02d/%04d", day, mon, year), -1, 8'h00);
  endtask

  // Lowers valid and waits until every queued verdict has been seen.
  task automatic wait_drained();
    @(negedge clk);
    char_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Well-formed dates hitting each verdict but the format error, and the leap-year rule at its edges.
  task automatic test_calendar_rules();
    send_date(29, 2, 2000);   // divisible by 400: leap
    send_date(29, 2, 1900);   // divisible by 100 only: not leap
    send_date(29, 2, 2024);
    send_date(29, 2, 2023);
    send_date(28, 2, 2023);
    send_date(31, 4, 2021);   // 31 in a 30-day month
    send_date(30, 11, 2021);
    send_date(31, 12, 9999);
    send_date(0, 1, 2000);
    send_date(32, 1, 2000);
    send_date(15, 0, 2000);
    send_date(15, 13, 2000);
    send_date(1, 1, 0);       // year zero
    send_date(99, 99, 9999);  // month wins over day
    send_date(1, 1, 1);
  endtask

  // Broken layouts: short, long, wrong separators, stray bytes at both ends of the range.
  task automatic test_format_errors();
    send_str("1/01/2000", -1, 8'h00);
    send_str("01/01/20000", -1, 8'h00);
    send_str("01/01/2000123", -1, 8'h00);   // position saturates at ten
    send_str("01-01-2000", -1, 8'h00);
    send_str("01/01/2000", 4, 8'h00);       // zero byte in the month
    send_str("01/01/2000", 9, 8'hFF);
    send_str("01/01/2000", 0, 8'h3A);       // one past the digit range
    send_str("01/01/2000", 7, SLASH_CHAR);  // slash where a digit belongs
    send_str("7", -1, 8'h00);               // single-character text
    send_str("/", -1, 8'h00);
  endtask

  // Random well-formed dates, sometimes bent toward February or broken on purpose.
  task automatic test_random_dates(input int n_texts);
    int day;
    int mon;
    int year;
    int kind;
    int swap_idx;
    string s;
    for (int t = 0; t < n_texts; t++) begin
      // A stretch with no idling on either side every so often.
      quiet = ((t / 15) % 4 == 3);
      day = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 31) : $urandom_range(0, 99);
      mon = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) begin
        mon = 2;
        day = $urandom_range(27, 30);
      end
      case ($urandom_range(0, 7))
        0:       year = 0;
        1:       year = 400 * $urandom_range(0, 24);
        2:       year = 100 * $urandom_range(0, 99);
        3:       year = 4 * $urandom_range(0, 2499);
        default: year = $urandom_range(0, 9999);
      endcase
      s = $sformatf("%02d/%02d/%04d", day, mon, year);
      swap_idx = -1;
      kind = $urandom_range(0, 15);
      if (kind == 0) s = s.substr(0, $urandom_range(0, 8));
      else if (kind == 1) s = {s, $sformatf("%0d", $urandom_range(0, 999))};
      else if (kind == 2) swap_idx = $urandom_range(0, 9);
      send_str(s, swap_idx, 8'($urandom_range(0, 255)));
      if (t % 25 == 24) wait_drained();
    end
    quiet = 1'b0;
  endtask

  // Character noise: random lengths, random bytes with digits and slashes favored.
  task automatic test_random_noise(input int n_chars);
    int len;
    int r;
    logic [7:0] c;
    int sent;
    sent = 0;
    while (sent < n_chars) begin
      len = $urandom_range(1, 14);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 9);
        if (r < 4) c = DIGIT_LOW + 8'($urandom_range(0, 9));
        else if (r < 5) c = SLASH_CHAR;
        else c = 8'($urandom_range(0, 255));
        send_char(c, i == len - 1);
      end
      sent += len;
    end
  endtask

  // The sender holds back until the block has answered everything, then bursts.
  task automatic test_drain_pause();
    wait_drained();
    send_date(12, 6, 1987);
    wait_drained();
    quiet = 1'b1;
    send_date(31, 1, 2001);
    send_date(30, 2, 2004);
    send_str("31/09/2010", -1, 8'h00);
    quiet = 1'b0;
    wait_drained();
  endtask

  // Sink side: ready drops for random stretches, mostly short, a few long.
  always @(negedge clk) begin
    if (rst) begin
      stall_left = 0;
      verdict_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      verdict_ch.ready <= 1'b0;
    end else begin
      verdict_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Every accepted verdict word is matched against the oldest expectation.
  always @(posedge clk) begin : check_verdict
    verdict_t want;
    if (!rst && verdict_ch.valid && verdict_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict word with nothing expected: date_ok %0d error_code %0d",
               verdict_ch.date_ok, verdict_ch.error_code);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict_ch.date_ok !== want.ok) begin
          $error("date_ok: expected %0d, got %0d", want.ok, verdict_ch.date_ok);
          error_count++;
        end
        if (verdict_ch.error_code !== want.code) begin
          $error("error_code: expected %0d, got %0d", want.code, verdict_ch.error_code);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a run that hangs ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst                  = 1'b1;
    char_ch.valid        = 1'b0;
    char_ch.char_code    = 8'h00;
    char_ch.last_char    = 1'b0;
    quiet                = 1'b0;
    error_count          = 0;
    cycle_count          = 0;
    clear_scan();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_calendar_rules();
    test_format_errors();
    test_drain_pause();
    test_random_dates(100);
    test_random_noise(260);

    // Everything is sent; let the last verdicts come out, then a short tail.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d verdict words never arrived", pending_verdicts.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
